// ===== sv/ieval_pkg.sv =====
// ----------------------------------------------------------------------------
// ieval_pkg
// Shared types and constants of the infix expression evaluator.
// ----------------------------------------------------------------------------
package ieval_pkg;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        OP_PAREN = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISSING  = 2'd1,
        ST_DIVZERO  = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MODE_CLOSE = 2'd0,
        MODE_OPER  = 2'd1,
        MODE_FINAL = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_END_CHK, S_OPRD, S_OPWAIT, S_AP1, S_AP2, S_AP3,
        S_EXEC, S_DIV, S_PUSH, S_RESULT, S_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_out_beat;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic push_digit;
        logic push_paren;
        logic push_oper;
        logic rd_op;
        logic pop_op;
        logic rd_b;
        logic rd_a;
        logic cap_a;
        logic exec;
        logic push_res;
        logic flag_miss;
        logic rd_res;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_digit;
        logic is_lparen;
        logic is_rparen;
        logic is_oper;
        logic oper_high;
        logic last;
        logic err_ok;
        logic op_empty;
        logic top_paren;
        logic top_low;
        logic opd_ge2;
        logic is_div;
        logic div_zero;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/infix_expression_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core
// Two-stack infix evaluator over single-digit operands and + - * / ( ).
//
//   channel | direction | handshake                 | beat
//   in      | input     | i_in_valid / o_in_ready   | character, last
//   out     | output    | o_out_valid / i_out_ready | value, status
//
// One character at a time: a digit, '(' or ignored character passes IDLE,
// DECODE and END_CHK; ')' and operators read the stack top in OPRD/OPWAIT,
// each reduced operator AP1-AP3, EXEC, PUSH; a division the bit-serial divider.
// After the last: RESULT, then EMIT, which waits while the result register is full.
// Reset is synchronous and clears counts, status and handshake state.
// The result register lets the next expression start while a result waits.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_core
    import ieval_pkg::*;
#(
    parameter int STACK_DEPTH = 128
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    t_cmd cmd;
    t_sts sts;

    ieval_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    ieval_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK || o_out_data.value == 32'sd0))
        else $error("error result carries nonzero value");

    a_one_beat_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a beat is in work");

    a_emit_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result loaded while idle");

endmodule

// ===== sv/ieval_ctrl.sv =====
// ----------------------------------------------------------------------------
// ieval_ctrl
// Sequencer: walks each character through push, reduce and result steps.
// ----------------------------------------------------------------------------
module ieval_ctrl
    import ieval_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_sts   i_sts,
    output logic   o_in_ready,
    output t_cmd   o_cmd
);

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_CLOSE;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (!i_sts.err_ok) begin
                    n_state = i_sts.last ? S_RESULT : S_IDLE;
                end else if (i_sts.is_rparen) begin
                    n_mode  = MODE_CLOSE;
                    n_state = S_OPRD;
                end else if (i_sts.is_oper) begin
                    n_mode  = MODE_OPER;
                    n_state = S_OPRD;
                end else begin
                    n_state = S_END_CHK;
                end
            end
            S_END_CHK: begin
                if (i_sts.last) begin
                    n_mode  = MODE_FINAL;
                    n_state = S_OPRD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OPRD: begin
                if (i_sts.op_empty || !i_sts.err_ok) begin
                    n_state = (r_mode == MODE_FINAL) ? S_RESULT : S_END_CHK;
                end else begin
                    n_state = S_OPWAIT;
                end
            end
            S_OPWAIT: begin
                unique case (r_mode)
                    MODE_CLOSE: n_state = i_sts.top_paren ? S_END_CHK : S_AP1;
                    MODE_OPER: begin
                        if (i_sts.top_paren || (i_sts.oper_high && i_sts.top_low))
                            n_state = S_END_CHK;
                        else
                            n_state = S_AP1;
                    end
                    default: n_state = i_sts.top_paren ? S_OPRD : S_AP1;
                endcase
            end
            S_AP1:    n_state = i_sts.opd_ge2 ? S_AP2 : S_OPRD;
            S_AP2:    n_state = S_AP3;
            S_AP3:    n_state = S_EXEC;
            S_EXEC: begin
                if (i_sts.is_div) n_state = i_sts.div_zero ? S_OPRD : S_DIV;
                else              n_state = S_PUSH;
            end
            S_DIV:    n_state = i_sts.div_busy ? S_DIV : S_PUSH;
            S_PUSH:   n_state = S_OPRD;
            S_RESULT: n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.push_digit = i_sts.err_ok && i_sts.is_digit;
                o_cmd.push_paren = i_sts.err_ok && i_sts.is_lparen;
            end
            S_OPRD: begin
                if (i_sts.op_empty || !i_sts.err_ok)
                    o_cmd.push_oper = (r_mode == MODE_OPER) && i_sts.err_ok;
                else
                    o_cmd.rd_op = 1'b1;
            end
            S_OPWAIT: begin
                if (r_mode == MODE_OPER
                    && (i_sts.top_paren || (i_sts.oper_high && i_sts.top_low)))
                    o_cmd.push_oper = 1'b1;
                else
                    o_cmd.pop_op = 1'b1;
            end
            S_AP1: begin
                o_cmd.rd_b      = i_sts.opd_ge2;
                o_cmd.flag_miss = !i_sts.opd_ge2;
            end
            S_AP2:    o_cmd.rd_a     = 1'b1;
            S_AP3:    o_cmd.cap_a    = 1'b1;
            S_EXEC:   o_cmd.exec     = 1'b1;
            S_PUSH:   o_cmd.push_res = 1'b1;
            S_RESULT: o_cmd.rd_res   = 1'b1;
            S_EMIT:   o_cmd.emit     = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// ===== sv/ieval_dp.sv =====
// ----------------------------------------------------------------------------
// ieval_dp
// Datapath: operand and operator stacks, ALU, serial divider, result register.
// ----------------------------------------------------------------------------
module ieval_dp
    import ieval_pkg::*;
#(
    parameter int STACK_DEPTH = 128
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in_data,
    input  logic      i_out_ready,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_beat o_out_data
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    logic [7:0]       r_ch;
    logic             r_last;
    logic [CNT_W-1:0] r_opd_cnt, r_op_cnt;
    t_status          r_err, n_err;
    logic [31:0]      r_opd_mem [STACK_DEPTH];
    logic [2:0]       r_op_mem  [STACK_DEPTH];
    t_opcode          r_op_rd, r_code;
    logic [31:0]      r_opd_rd, r_a, r_b, r_res;
    logic [31:0]      r_quo, r_rem, r_mb;
    logic             r_neg, r_div_busy;
    logic [5:0]       r_div_cnt;
    logic             r_out_valid;
    t_out_beat        r_out_data;

    logic             is_digit, is_lparen, is_rparen, is_oper;
    t_opcode          ch_code;
    logic [7:0]       digit;
    logic             opd_full, op_full, out_free;
    logic [CNT_W-1:0] opd_m1, opd_m2, op_m1;
    logic             opd_push, op_push;
    logic [31:0]      opd_wdata;
    t_opcode          op_wdata;
    logic [32:0]      trial;
    logic [31:0]      q_next, rem_next;

    assign is_digit  = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
    assign is_lparen = (r_ch == CH_LPAREN);
    assign is_rparen = (r_ch == CH_RPAREN);
    assign is_oper   = (r_ch == CH_PLUS) || (r_ch == CH_MINUS)
                    || (r_ch == CH_STAR) || (r_ch == CH_SLASH);
    assign digit     = r_ch - CH_ZERO;

    always_comb begin
        case (r_ch)
            CH_PLUS:  ch_code = OP_ADD;
            CH_MINUS: ch_code = OP_SUB;
            CH_STAR:  ch_code = OP_MUL;
            default:  ch_code = OP_DIV;
        endcase
    end

    assign opd_full = (r_opd_cnt == CNT_W'(STACK_DEPTH));
    assign op_full  = (r_op_cnt == CNT_W'(STACK_DEPTH));
    assign opd_m1   = r_opd_cnt - CNT_W'(1);
    assign opd_m2   = r_opd_cnt - CNT_W'(2);
    assign op_m1    = r_op_cnt - CNT_W'(1);
    assign out_free = !r_out_valid || i_out_ready;

    assign opd_push  = (i_cmd.push_digit || i_cmd.push_res) && !opd_full;
    assign opd_wdata = i_cmd.push_res ? r_res : {28'd0, digit[3:0]};
    assign op_push   = (i_cmd.push_paren || i_cmd.push_oper) && !op_full;
    assign op_wdata  = i_cmd.push_paren ? OP_PAREN : ch_code;

    // first error sticks
    always_comb begin
        n_err = r_err;
        if (i_cmd.emit) begin
            n_err = ST_OK;
        end else if (r_err == ST_OK) begin
            if (((i_cmd.push_digit || i_cmd.push_res) && opd_full)
                || ((i_cmd.push_paren || i_cmd.push_oper) && op_full))
                n_err = ST_OVERFLOW;
            else if (i_cmd.flag_miss || (i_cmd.rd_res && r_opd_cnt == '0))
                n_err = ST_MISSING;
            else if (i_cmd.exec && r_code == OP_DIV && r_b == '0)
                n_err = ST_DIVZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opd_cnt <= '0;
            r_op_cnt  <= '0;
            r_err     <= ST_OK;
        end else begin
            r_err <= n_err;
            if (i_cmd.emit)          r_opd_cnt <= '0;
            else if (i_cmd.cap_a)    r_opd_cnt <= opd_m2;
            else if (opd_push)       r_opd_cnt <= r_opd_cnt + CNT_W'(1);
            if (i_cmd.emit)          r_op_cnt <= '0;
            else if (i_cmd.pop_op)   r_op_cnt <= op_m1;
            else if (op_push)        r_op_cnt <= r_op_cnt + CNT_W'(1);
        end
    end

    // stack memories
    always_ff @(posedge i_clk) begin
        if (opd_push) r_opd_mem[r_opd_cnt[IDX_W-1:0]] <= opd_wdata;
        if (i_cmd.rd_b || i_cmd.rd_res) r_opd_rd <= r_opd_mem[opd_m1[IDX_W-1:0]];
        else if (i_cmd.rd_a)            r_opd_rd <= r_opd_mem[opd_m2[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (op_push)     r_op_mem[r_op_cnt[IDX_W-1:0]] <= op_wdata;
        if (i_cmd.rd_op) r_op_rd <= t_opcode'(r_op_mem[op_m1[IDX_W-1:0]]);
    end

    // input latch and operand capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch   <= i_in_data.character;
            r_last <= i_in_data.last;
        end
        if (i_cmd.pop_op) r_code <= r_op_rd;
        if (i_cmd.rd_a)   r_b    <= r_opd_rd;
        if (i_cmd.cap_a)  r_a    <= r_opd_rd;
    end

    // restoring divider step on magnitudes
    assign trial    = {r_rem, r_quo[31]} - {1'b0, r_mb};
    assign rem_next = trial[32] ? {r_rem[30:0], r_quo[31]} : trial[31:0];
    assign q_next   = {r_quo[30:0], !trial[32]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (i_cmd.exec && r_code == OP_DIV && r_b != '0) begin
            r_div_busy <= 1'b1;
        end else if (r_div_busy && r_div_cnt == 6'd1) begin
            r_div_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            case (r_code)
                OP_ADD:  r_res <= r_a + r_b;
                OP_SUB:  r_res <= r_a - r_b;
                OP_MUL:  r_res <= r_a * r_b;
                default: begin
                    r_neg     <= r_a[31] ^ r_b[31];
                    r_quo     <= r_a[31] ? (32'd0 - r_a) : r_a;
                    r_mb      <= r_b[31] ? (32'd0 - r_b) : r_b;
                    r_rem     <= '0;
                    r_div_cnt <= 6'd32;
                end
            endcase
        end else if (r_div_busy) begin
            r_quo     <= q_next;
            r_rem     <= rem_next;
            r_div_cnt <= r_div_cnt - 6'd1;
            if (r_div_cnt == 6'd1) r_res <= r_neg ? (32'd0 - q_next) : q_next;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.value  <= (r_err == ST_OK) ? $signed(r_opd_rd) : 32'sd0;
            r_out_data.status <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_sts.is_digit  = is_digit;
        o_sts.is_lparen = is_lparen;
        o_sts.is_rparen = is_rparen;
        o_sts.is_oper   = is_oper;
        o_sts.oper_high = (ch_code == OP_MUL) || (ch_code == OP_DIV);
        o_sts.last      = r_last;
        o_sts.err_ok    = (r_err == ST_OK);
        o_sts.op_empty  = (r_op_cnt == '0);
        o_sts.top_paren = (r_op_rd == OP_PAREN);
        o_sts.top_low   = (r_op_rd == OP_ADD) || (r_op_rd == OP_SUB);
        o_sts.opd_ge2   = (r_opd_cnt >= CNT_W'(2));
        o_sts.is_div    = (r_code == OP_DIV);
        o_sts.div_zero  = (r_b == '0);
        o_sts.div_busy  = r_div_busy;
        o_sts.out_free  = out_free;
    end

endmodule

// ===== verif/infix_expression_evaluator_core_tb.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core_tb
// Drives expressions character by character into the evaluator and checks
// each value/status beat against a two-stack evaluator kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module infix_expression_evaluator_core_tb;
    import ieval_pkg::*;

    localparam int DEPTH = 128;
    localparam int WATCHDOG_LIMIT = 20000;

    // ------------------------------------------------------------------------
    // Bench copy of the evaluator: two stacks, counts and a sticky status.
    // ------------------------------------------------------------------------
    class expr_scoreboard;
        logic [31:0] operands [DEPTH];
        t_opcode     operators [DEPTH];
        int          n_operands;
        int          n_operators;
        t_status     err;
        t_out_beat   pending_results [$];
        int          n_errors;

        function void clear_expr();
            n_operands  = 0;
            n_operators = 0;
            err         = ST_OK;
        endfunction

        function void raise(t_status code);
            if (err == ST_OK) err = code;
        endfunction

        function void push_operand(logic [31:0] v);
            if (n_operands >= DEPTH) begin
                raise(ST_OVERFLOW);
                return;
            end
            operands[n_operands] = v;
            n_operands++;
        endfunction

        function void push_operator(t_opcode code);
            if (n_operators >= DEPTH) begin
                raise(ST_OVERFLOW);
                return;
            end
            operators[n_operators] = code;
            n_operators++;
        endfunction

        function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
            logic [31:0] ma;
            logic [31:0] mb;
            logic [31:0] q;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q  = ma / mb;
            return (a[31] != b[31]) ? -q : q;
        endfunction

        function void reduce(t_opcode code);
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] r;
            if (n_operands < 2) begin
                raise(ST_MISSING);
                return;
            end
            b = operands[n_operands-1];
            a = operands[n_operands-2];
            n_operands -= 2;
            case (code)
                OP_ADD: r = a + b;
                OP_SUB: r = a - b;
                OP_MUL: r = a * b;
                default: begin
                    if (b == 0) begin
                        raise(ST_DIVZERO);
                        return;
                    end
                    r = quotient(a, b);
                end
            endcase
            push_operand(r);
        endfunction

        function void take_char(logic [7:0] ch);
            t_opcode code;
            t_opcode top;
            bit      high;
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                push_operand(32'(ch - CH_ZERO));
            end else if (ch == CH_LPAREN) begin
                push_operator(OP_PAREN);
            end else if (ch == CH_RPAREN) begin
                while (n_operators > 0 && err == ST_OK) begin
                    top = operators[n_operators-1];
                    n_operators--;
                    if (top == OP_PAREN) break;
                    reduce(top);
                end
            end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR
                         || ch == CH_SLASH) begin
                code = (ch == CH_PLUS) ? OP_ADD : (ch == CH_MINUS) ? OP_SUB
                     : (ch == CH_STAR) ? OP_MUL : OP_DIV;
                high = (code == OP_MUL || code == OP_DIV);
                while (n_operators > 0 && err == ST_OK) begin
                    top = operators[n_operators-1];
                    if (top == OP_PAREN || (high && (top == OP_ADD || top == OP_SUB)))
                        break;
                    n_operators--;
                    reduce(top);
                end
                if (err == ST_OK) push_operator(code);
            end
        endfunction

        // note one accepted input beat
        function void note_input(t_in_beat b);
            t_out_beat res;
            t_opcode   top;
            if (err == ST_OK) take_char(b.character);
            if (!b.last) return;
            while (n_operators > 0 && err == ST_OK) begin
                top = operators[n_operators-1];
                n_operators--;
                if (top != OP_PAREN) reduce(top);
            end
            if (err == ST_OK && n_operands == 0) raise(ST_MISSING);
            res.status = err;
            res.value  = (err == ST_OK) ? operands[n_operands-1] : 32'd0;
            pending_results.push_back(res);
            clear_expr();
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat exp_b;
            if (pending_results.size() == 0) begin
                $error("unexpected result value=%0d status=%0d", got.value, got.status);
                n_errors++;
                return;
            end
            exp_b = pending_results.pop_front();
            if (got.value !== exp_b.value) begin
                $error("value: expected %0d, actual %0d", exp_b.value, got.value);
                n_errors++;
            end
            if (got.status !== exp_b.status) begin
                $error("status: expected %0d, actual %0d", exp_b.status, got.status);
                n_errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_beat  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_beat out_data;

    expr_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  stim_done;
    int  quiet_cycles;
    bit  timed_out;
    int  n_sent;

    infix_expression_evaluator_core #(.STACK_DEPTH(DEPTH)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial clk = 1'b0;
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver side: random stall, check every accepted beat
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) sb.check_result(out_data);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk) begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // send one beat; idle gap beforehand at the current rate
    task automatic send_char(logic [7:0] ch, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_data.character <= ch;
        in_data.last      <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input('{character: ch, last: last});
        n_sent++;
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_char(bit noisy);
        int r;
        r = $urandom_range(99);
        if (noisy && r < 5) return 8'($urandom_range(255));
        if (r < 45) return CH_ZERO + 8'($urandom_range(9));
        if (r < 55) return CH_LPAREN;
        if (r < 65) return CH_RPAREN;
        case ($urandom_range(3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // well-formed expression with random digits/ops/parens
    task automatic send_wellformed(int n_terms);
        int opens;
        opens = 0;
        for (int t = 0; t < n_terms; t++) begin
            if ($urandom_range(3) == 0) begin
                send_char(CH_LPAREN, 1'b0);
                opens++;
            end
            send_char(CH_ZERO + 8'($urandom_range(9)), 1'b0);
            if (opens > 0 && $urandom_range(2) == 0) begin
                send_char(CH_RPAREN, 1'b0);
                opens--;
            end
            if (t < n_terms - 1) begin
                case ($urandom_range(3))
                    0: send_char(CH_PLUS, 1'b0);
                    1: send_char(CH_MINUS, 1'b0);
                    2: send_char(CH_STAR, 1'b0);
                    default: send_char(CH_SLASH, 1'b0);
                endcase
            end
        end
        while (opens > 0) begin
            send_char(CH_RPAREN, 1'b0);
            opens--;
        end
        send_char(" ", 1'b1);
    endtask

    task automatic run_phase(int n_items);
        int start;
        int len;
        start = n_sent;
        while (n_sent - start < n_items) begin
            if ($urandom_range(9) < 7) begin
                len = $urandom_range(1, 8);
                send_wellformed(len);
            end else begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) send_char(pick_char(1'b1), i == len - 1);
            end
        end
    endtask

    initial begin
        sb = new();
        sb.clear_expr();
        sb.n_errors   = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        stim_done     = 1'b0;
        timed_out     = 1'b0;
        n_sent        = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: operators, precedence, parens and each error status
        send_string("7");
        send_string("9*9-3/2+(8-9)");
        send_string("(1+2)*3");
        send_string("8/0");
        send_string("+");
        send_string("");
        send_char(8'hFF, 1'b1);
        send_string("0-7/2");
        send_string("1+2)*3");
        send_string("((4");
        send_string("12+");
        send_string("a1b+c2");
        // wrap: 9^10 overflows signed 32 bits
        send_string("9*9*9*9*9*9*9*9*9*9");
        // most negative / -1: build -2^31 as (0-8)*8^9*2, then divide by (0-1)
        send_string("(0-8)*8*8*8*8*8*8*8*8*8*2/(0-1)");
        for (int i = 0; i < DEPTH + 1; i++) send_char(CH_ZERO + 8'(i % 10), 1'b0);
        send_char(CH_PLUS, 1'b1);
        for (int i = 0; i < DEPTH + 1; i++) send_char(CH_LPAREN, 1'b0);
        send_char(CH_ZERO + 8'd1, 1'b1);

        send_idle_pct = 25; recv_idle_pct = 71;
        run_phase(400);
        send_idle_pct = 71; recv_idle_pct = 25;
        run_phase(400);
        send_idle_pct = 0;  recv_idle_pct = 0;
        run_phase(390);
        in_valid  <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
                break;
            end
            if (stim_done && sb.pending_results.size() == 0) break;
        end
        if (timed_out) begin
            $display("TB_ERROR");
        end else begin
            repeat (200) @(posedge clk);
            if (sb.n_errors == 0 && sb.pending_results.size() == 0)
                $display("TB_OK");
            else
                $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/ieval_pkg.sv
sv/ieval_ctrl.sv
sv/ieval_dp.sv
sv/infix_expression_evaluator_core.sv
verif/infix_expression_evaluator_core_tb.sv
